// ----- rtl/lsc_pkg.sv -----
// Package for the line sensor centroid block: shared types, constants,
// register indexes and the divider request/response structs.
// Used by lsc_div and line_sensor_centroid_top.
`default_nettype none

package lsc_pkg;

    localparam int CHANNELS = 8;
    localparam int SAMPLE_W = 12;
    localparam int CFG_W    = 48;
    localparam int IDX_W    = 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;

    // Shared divider: quotient is known to fit in QUO_W bits
    localparam int QUO_W  = 12;
    localparam int DVD_W  = 27;
    localparam int DVS_W  = 15;
    localparam int CNT_W  = 4;

    localparam int STR_W  = 15;
    localparam int WSUM_W = 28;
    localparam int ERR_W  = 13;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_WHITE_LO = 2'd0;
    localparam logic [IDX_W-1:0] CFG_WHITE_HI = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BLACK_LO = 2'd2;
    localparam logic [IDX_W-1:0] CFG_BLACK_HI = 2'd3;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic signed [ERR_W-1:0] t_err;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quotient;
    } t_div_rsp;

    // Position weight of each channel: -3500 + 1000 * ch
    function automatic t_err pos_weight(input logic [2:0] ch);
        t_err w;
        case (ch)
            3'd0:    w = -13'sd3500;
            3'd1:    w = -13'sd2500;
            3'd2:    w = -13'sd1500;
            3'd3:    w = -13'sd500;
            3'd4:    w = 13'sd500;
            3'd5:    w = 13'sd1500;
            3'd6:    w = 13'sd2500;
            3'd7:    w = 13'sd3500;
            default: w = 13'sd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lsc_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Requires dividend >> QUO_W < divisor. Depends on lsc_pkg.
`default_nettype none

module lsc_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lsc_pkg::t_div_req i_req,
    output lsc_pkg::t_div_rsp      o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [lsc_pkg::CNT_W-1:0]   r_cnt;
    logic [lsc_pkg::DVS_W-1:0]   r_rem;
    logic [lsc_pkg::DVS_W-1:0]   r_div;
    logic [lsc_pkg::QUO_W-1:0]   r_low;
    logic [lsc_pkg::QUO_W-1:0]   r_quo;

    logic [lsc_pkg::DVS_W:0]     trial;
    logic [lsc_pkg::DVS_W:0]     diff;
    logic                        ge;
    logic [lsc_pkg::DVS_W-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_low[lsc_pkg::QUO_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[lsc_pkg::DVS_W-1:0] : trial[lsc_pkg::DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == lsc_pkg::CNT_W'(lsc_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[lsc_pkg::DVD_W-1:lsc_pkg::QUO_W];
            r_low <= i_req.dividend[lsc_pkg::QUO_W-1:0];
            r_div <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[lsc_pkg::QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[lsc_pkg::QUO_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ----- rtl/line_sensor_centroid_top.sv -----
// Line sensor centroid: calibration registers, channel sequencer and output
// register around the shared divider. Depends on lsc_pkg and lsc_div.
// Each channel passes through S_CHAN and S_ACC, with S_NDIV between them when
// its normalization goes through the 12-step divider; for a nonzero strength
// the centroid division runs in S_FDIV between S_FIN and S_OUT. The block takes
// one frame at a time: the input stalls until the result is loaded into the
// output register. Reset clears control state, calibration (white all ones,
// black zero), the digital bits and the held error.
`default_nettype none

module line_sensor_centroid_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [lsc_pkg::SAMPLE_W-1:0]  i_raw_0,
    input  wire logic [lsc_pkg::SAMPLE_W-1:0]  i_raw_1,
    input  wire logic [lsc_pkg::SAMPLE_W-1:0]  i_raw_2,
    input  wire logic [lsc_pkg::SAMPLE_W-1:0]  i_raw_3,
    input  wire logic [lsc_pkg::SAMPLE_W-1:0]  i_raw_4,
    input  wire logic [lsc_pkg::SAMPLE_W-1:0]  i_raw_5,
    input  wire logic [lsc_pkg::SAMPLE_W-1:0]  i_raw_6,
    input  wire logic [lsc_pkg::SAMPLE_W-1:0]  i_raw_7,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [lsc_pkg::SAMPLE_W-1:0]       o_norm_0,
    output logic [lsc_pkg::SAMPLE_W-1:0]       o_norm_1,
    output logic [lsc_pkg::SAMPLE_W-1:0]       o_norm_2,
    output logic [lsc_pkg::SAMPLE_W-1:0]       o_norm_3,
    output logic [lsc_pkg::SAMPLE_W-1:0]       o_norm_4,
    output logic [lsc_pkg::SAMPLE_W-1:0]       o_norm_5,
    output logic [lsc_pkg::SAMPLE_W-1:0]       o_norm_6,
    output logic [lsc_pkg::SAMPLE_W-1:0]       o_norm_7,
    output logic [7:0]                         o_white_bits,
    output logic [3:0]                         o_dark_count,
    output logic [lsc_pkg::STR_W-1:0]          o_strength,
    output logic signed [lsc_pkg::ERR_W-1:0]   o_line_offset,
    // configuration port
    input  wire logic                          i_cfg_we,
    input  wire logic [lsc_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [lsc_pkg::CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHAN = 7'b0000010,
        S_NDIV = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_FDIV = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    localparam int CH_N = lsc_pkg::CHANNELS;
    localparam int SW   = lsc_pkg::SAMPLE_W;

    t_state                          r_state;
    t_state                          n_state;

    logic [CH_N-1:0][SW-1:0]         r_white;
    logic [CH_N-1:0][SW-1:0]         r_black;
    logic [CH_N-1:0][SW-1:0]         r_raw;
    logic [CH_N-1:0][SW-1:0]         r_norms;
    logic [2:0]                      r_ch;
    logic [SW-1:0]                   r_norm;
    logic [7:0]                      r_bits;
    lsc_pkg::t_err                   r_last_err;
    lsc_pkg::t_err                   r_err;
    logic [lsc_pkg::STR_W-1:0]       r_strength;
    logic signed [lsc_pkg::WSUM_W-1:0] r_wsum;

    logic                            r_out_valid;
    logic [CH_N-1:0][SW-1:0]         r_o_norm;
    logic [7:0]                      r_o_bits;
    logic [3:0]                      r_o_dark;
    logic [lsc_pkg::STR_W-1:0]       r_o_strength;
    lsc_pkg::t_err                   r_o_err;

    lsc_pkg::t_div_req               div_req;
    lsc_pkg::t_div_rsp               div_rsp;

    logic                            in_accept;
    logic                            out_free;

    // Channel datapath
    logic [SW-1:0]                   cur_raw;
    logic [SW-1:0]                   cur_w;
    logic [SW-1:0]                   cur_b;
    logic                            cal_ok;
    logic [SW-1:0]                   raw_off;
    logic [SW-1:0]                   span;
    logic [2*SW-1:0]                 scaled;
    logic [SW+1:0]                   up_lhs;
    logic [SW+1:0]                   up_rhs;
    logic [SW+1:0]                   dn_lhs;
    logic [SW+1:0]                   dn_rhs;

    logic [SW-1:0]                   blk;
    logic signed [SW+lsc_pkg::ERR_W:0] blk_w;
    logic                            wsum_neg;
    logic signed [lsc_pkg::WSUM_W-1:0] wsum_mag;
    lsc_pkg::t_err                   quo_err;
    logic [3:0]                      dark;

    assign cur_raw = r_raw[r_ch];
    assign cur_w   = r_white[r_ch];
    assign cur_b   = r_black[r_ch];
    assign cal_ok  = (cur_w > cur_b);
    assign raw_off = cur_raw - cur_b;
    assign span    = cur_w - cur_b;
    assign scaled  = (2*SW)'(raw_off) * (2*SW)'(lsc_pkg::SAMPLE_MAX);

    // raw >= floor(x/3)  <=>  3*raw + 2 >= x;  raw <= floor(y/3)  <=>  3*raw <= y
    assign up_lhs = {cur_raw, 1'b0} + (SW+2)'(cur_raw) + (SW+2)'(2);
    assign up_rhs = (SW+2)'(cur_b) + {1'b0, cur_w, 1'b0};
    assign dn_lhs = {cur_raw, 1'b0} + (SW+2)'(cur_raw);
    assign dn_rhs = {1'b0, cur_b, 1'b0} + (SW+2)'(cur_w);

    assign blk   = lsc_pkg::SAMPLE_MAX - r_norm;
    assign blk_w = $signed({1'b0, blk}) * lsc_pkg::pos_weight(r_ch);

    assign wsum_neg = r_wsum[lsc_pkg::WSUM_W-1];
    assign wsum_mag = wsum_neg ? -r_wsum : r_wsum;
    assign quo_err  = wsum_neg ? -$signed({1'b0, div_rsp.quotient})
                               : $signed({1'b0, div_rsp.quotient});

    always_comb begin
        dark = '0;
        for (int i = 0; i < CH_N; i++) begin
            dark = dark + {3'b000, ~r_bits[i]};
        end
    end

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Divider requests: normalization of a channel, then the centroid
    always_comb begin
        div_req = '0;
        if (r_state == S_CHAN && cal_ok && cur_raw > cur_b && cur_raw < cur_w) begin
            div_req.start    = 1'b1;
            div_req.dividend = lsc_pkg::DVD_W'(scaled);
            div_req.divisor  = lsc_pkg::DVS_W'(span);
        end else if (r_state == S_FIN && r_strength != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = wsum_mag[lsc_pkg::DVD_W-1:0];
            div_req.divisor  = r_strength;
        end
    end

    lsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_CHAN;
                end
            end
            S_CHAN: begin
                n_state = div_req.start ? S_NDIV : S_ACC;
            end
            S_NDIV: begin
                if (div_rsp.done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = (r_ch == 3'(CH_N - 1)) ? S_FIN : S_CHAN;
            end
            S_FIN: begin
                n_state = div_req.start ? S_FDIV : S_OUT;
            end
            S_FDIV: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, calibration and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_bits      <= '0;
            r_last_err  <= '0;
            r_ch        <= '0;
            r_white     <= '1;
            r_black     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    lsc_pkg::CFG_WHITE_LO: r_white[3:0] <= i_cfg_data;
                    lsc_pkg::CFG_WHITE_HI: r_white[7:4] <= i_cfg_data;
                    lsc_pkg::CFG_BLACK_LO: r_black[3:0] <= i_cfg_data;
                    lsc_pkg::CFG_BLACK_HI: r_black[7:4] <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_accept) begin
                r_ch <= '0;
            end else if (r_state == S_ACC) begin
                r_ch <= r_ch + 1'b1;
            end

            // Hysteresis: set at or above upper threshold, clear at or below lower, else hold
            if (r_state == S_CHAN && cal_ok) begin
                if (up_lhs >= up_rhs) begin
                    r_bits[r_ch] <= 1'b1;
                end else if (dn_lhs <= dn_rhs) begin
                    r_bits[r_ch] <= 1'b0;
                end
            end

            if (r_state == S_FIN && r_strength == '0) begin
                r_err <= r_last_err;
            end else if (r_state == S_FDIV && div_rsp.done) begin
                r_err      <= quo_err;
                r_last_err <= quo_err;
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_raw      <= {i_raw_7, i_raw_6, i_raw_5, i_raw_4,
                           i_raw_3, i_raw_2, i_raw_1, i_raw_0};
            r_strength <= '0;
            r_wsum     <= '0;
        end

        if (r_state == S_CHAN) begin
            if (!cal_ok || cur_raw <= cur_b) begin
                r_norm <= '0;
            end else begin
                r_norm <= lsc_pkg::SAMPLE_MAX;
            end
        end else if (r_state == S_NDIV && div_rsp.done) begin
            r_norm <= div_rsp.quotient;
        end

        if (r_state == S_ACC) begin
            r_norms[r_ch] <= r_norm;
            if (r_norm != lsc_pkg::SAMPLE_MAX) begin
                r_strength <= r_strength + lsc_pkg::STR_W'(blk);
                r_wsum     <= r_wsum + lsc_pkg::WSUM_W'(blk_w);
            end
        end

        if (r_state == S_OUT && out_free) begin
            r_o_norm     <= r_norms;
            r_o_bits     <= r_bits;
            r_o_dark     <= dark;
            r_o_strength <= r_strength;
            r_o_err      <= r_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_norm_0      = r_o_norm[0];
    assign o_norm_1      = r_o_norm[1];
    assign o_norm_2      = r_o_norm[2];
    assign o_norm_3      = r_o_norm[3];
    assign o_norm_4      = r_o_norm[4];
    assign o_norm_5      = r_o_norm[5];
    assign o_norm_6      = r_o_norm[6];
    assign o_norm_7      = r_o_norm[7];
    assign o_white_bits  = r_o_bits;
    assign o_dark_count  = r_o_dark;
    assign o_strength    = r_o_strength;
    assign o_line_offset = r_o_err;

endmodule

`default_nettype wire

// ----- tb/line_sensor_centroid_top_tb.sv -----
// Self-checking testbench for line_sensor_centroid_top: normalization, hysteresis bits,
// strength and centroid of each frame, checked against an in-bench predictor.
// Depends on lsc_pkg and the line_sensor_centroid_top RTL.
`default_nettype none

module line_sensor_centroid_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_SCALE  = 4095;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int FRAMES_PER_PHASE = 213;

    typedef logic [lsc_pkg::CHANNELS-1:0][lsc_pkg::SAMPLE_W-1:0] t_frame;

    typedef struct packed {
        t_frame                     norm;
        logic [7:0]                 white_bits;
        logic [3:0]                 dark_count;
        logic [lsc_pkg::STR_W-1:0]  strength;
        lsc_pkg::t_err              line_offset;
    } t_centroid;

    typedef enum int {CAL_FULL, CAL_SPREAD, CAL_NARROW, CAL_MIXED} t_cal_style;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_frame               raw_bus = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_frame               norm_out;
    logic [7:0]           white_bits_out;
    logic [3:0]           dark_count_out;
    logic [lsc_pkg::STR_W-1:0]        strength_out;
    logic signed [lsc_pkg::ERR_W-1:0] line_offset_out;
    logic                             cfg_we = 1'b0;
    logic [lsc_pkg::IDX_W-1:0]        cfg_index = lsc_pkg::CFG_WHITE_LO;
    logic [lsc_pkg::CFG_W-1:0]        cfg_data = '0;

    // predictor copy of calibration and state
    logic [lsc_pkg::CFG_W-1:0] cal_white_lo = '1;
    logic [lsc_pkg::CFG_W-1:0] cal_white_hi = '1;
    logic [lsc_pkg::CFG_W-1:0] cal_black_lo = '0;
    logic [lsc_pkg::CFG_W-1:0] cal_black_hi = '0;
    logic [7:0]           held_bits = '0;
    lsc_pkg::t_err        held_error = '0;

    t_centroid            pending_centroids[$];
    int                   mismatches = 0;
    int                   cycle_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   stall_left = 0;

    line_sensor_centroid_top u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_raw_0       (raw_bus[0]),
        .i_raw_1       (raw_bus[1]),
        .i_raw_2       (raw_bus[2]),
        .i_raw_3       (raw_bus[3]),
        .i_raw_4       (raw_bus[4]),
        .i_raw_5       (raw_bus[5]),
        .i_raw_6       (raw_bus[6]),
        .i_raw_7       (raw_bus[7]),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_norm_0      (norm_out[0]),
        .o_norm_1      (norm_out[1]),
        .o_norm_2      (norm_out[2]),
        .o_norm_3      (norm_out[3]),
        .o_norm_4      (norm_out[4]),
        .o_norm_5      (norm_out[5]),
        .o_norm_6      (norm_out[6]),
        .o_norm_7      (norm_out[7]),
        .o_white_bits  (white_bits_out),
        .o_dark_count  (dark_count_out),
        .o_strength    (strength_out),
        .o_line_offset (line_offset_out),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic lsc_pkg::t_sample cal_field(input logic [lsc_pkg::CFG_W-1:0] lo,
                                                   input logic [lsc_pkg::CFG_W-1:0] hi,
                                                   input int ch);
        logic [lsc_pkg::CFG_W-1:0] r;
        r = (ch < 4) ? lo : hi;
        return r[lsc_pkg::SAMPLE_W*(ch%4) +: lsc_pkg::SAMPLE_W];
    endfunction

    // Normalize, update hysteresis bits and held error, return the expected transaction
    function automatic t_centroid compute_centroid(input t_frame raw);
        t_centroid r;
        int        v, w, b, n, up, dn, blk, str, dark;
        longint    wsum;
        logic [7:0] bits;
        bits = held_bits;
        str  = 0;
        wsum = 0;
        dark = 0;
        for (int ch = 0; ch < lsc_pkg::CHANNELS; ch++) begin
            v = raw[ch];
            w = cal_field(cal_white_lo, cal_white_hi, ch);
            b = cal_field(cal_black_lo, cal_black_hi, ch);
            if (w <= b || v <= b)
                n = 0;
            else if (v >= w)
                n = FULL_SCALE;
            else
                n = ((v - b) * FULL_SCALE) / (w - b);
            r.norm[ch] = n[lsc_pkg::SAMPLE_W-1:0];
            if (w > b) begin
                up = (b + 2 * w) / 3;
                dn = (2 * b + w) / 3;
                if (v >= up)
                    bits[ch] = 1'b1;
                else if (v <= dn)
                    bits[ch] = 1'b0;
            end
            if (n < FULL_SCALE) begin
                blk = FULL_SCALE - n;
                str += blk;
                // position weight runs -3500..3500 in steps of 1000
                wsum += longint'(blk) * longint'(ch * 1000 - 3500);
            end
        end
        for (int ch = 0; ch < lsc_pkg::CHANNELS; ch++)
            if (!bits[ch])
                dark++;
        if (str != 0)
            held_error = lsc_pkg::t_err'(wsum / longint'(str));
        held_bits     = bits;
        r.white_bits  = bits;
        r.dark_count  = dark[3:0];
        r.strength    = str[lsc_pkg::STR_W-1:0];
        r.line_offset = held_error;
        return r;
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_centroid();
        t_centroid want;
        if (pending_centroids.size() == 0) begin
            $display("%0t ns: result transaction with no frame pending, actual strength %0d",
                     $time, strength_out);
            mismatches++;
        end else begin
            want = pending_centroids.pop_front();
            for (int ch = 0; ch < lsc_pkg::CHANNELS; ch++)
                compare_field($sformatf("norm_%0d", ch), want.norm[ch], norm_out[ch]);
            compare_field("white_bits", want.white_bits, white_bits_out);
            compare_field("dark_count", want.dark_count, dark_count_out);
            compare_field("strength", want.strength, strength_out);
            compare_field("line_offset", $signed(want.line_offset), line_offset_out);
        end
    endtask

    // Result side: check accepted transactions, then pick the next stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            check_centroid();
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            stall_left = pick_gap(recv_idle_pct);
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Valid stays high after acceptance; drain_results, or the next call when it picks an idle gap, lowers it
    task automatic send_frame(input t_frame raw);
        int gap;
        gap = pick_gap(send_idle_pct);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_bus  <= raw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_centroids.push_back(compute_centroid(raw));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_centroids.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [lsc_pkg::IDX_W-1:0] idx,
                                  input logic [lsc_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            lsc_pkg::CFG_WHITE_LO: cal_white_lo = value;
            lsc_pkg::CFG_WHITE_HI: cal_white_hi = value;
            lsc_pkg::CFG_BLACK_LO: cal_black_lo = value;
            lsc_pkg::CFG_BLACK_HI: cal_black_hi = value;
            default: ;
        endcase
    endtask

    task automatic load_calibration(input t_frame white, input t_frame black);
        drain_results();
        write_register(lsc_pkg::CFG_WHITE_LO, white[3:0]);
        write_register(lsc_pkg::CFG_WHITE_HI, white[7:4]);
        write_register(lsc_pkg::CFG_BLACK_LO, black[3:0]);
        write_register(lsc_pkg::CFG_BLACK_HI, black[7:4]);
        cfg_we <= 1'b0;
    endtask

    function automatic t_frame flat_frame(input int v);
        t_frame f;
        for (int ch = 0; ch < lsc_pkg::CHANNELS; ch++)
            f[ch] = v[lsc_pkg::SAMPLE_W-1:0];
        return f;
    endfunction

    task automatic rand_calibration(input t_cal_style style, output t_frame white,
                                    output t_frame black);
        int w, b, pick;
        for (int ch = 0; ch < lsc_pkg::CHANNELS; ch++) begin
            pick = (style == CAL_MIXED) ? $urandom_range(0, 9) : 9;
            b = $urandom_range(0, 4000);
            w = $urandom_range(b + 1, FULL_SCALE);
            if (style == CAL_FULL || pick == 3) begin
                b = 0;
                w = FULL_SCALE;
            end else if (style == CAL_NARROW || pick == 2) begin
                b = $urandom_range(0, FULL_SCALE - 8);
                w = b + $urandom_range(1, 8);
            end else if (pick == 0) begin
                w = b;
            end else if (pick == 1) begin
                w = $urandom_range(0, b);
                b = $urandom_range(w + 1, FULL_SCALE);
            end
            white[ch] = w[lsc_pkg::SAMPLE_W-1:0];
            black[ch] = b[lsc_pkg::SAMPLE_W-1:0];
        end
    endtask

    // Aim samples at thresholds and calibration edges as often as at random values
    function automatic t_frame rand_frame();
        t_frame f;
        int     v, w, b, up, dn;
        for (int ch = 0; ch < lsc_pkg::CHANNELS; ch++) begin
            w  = cal_field(cal_white_lo, cal_white_hi, ch);
            b  = cal_field(cal_black_lo, cal_black_hi, ch);
            up = (b + 2 * w) / 3;
            dn = (2 * b + w) / 3;
            case ($urandom_range(0, 9))
                3:       v = up + $urandom_range(0, 6) - 3;
                4:       v = dn + $urandom_range(0, 6) - 3;
                5:       v = b + $urandom_range(0, 4) - 2;
                6:       v = w + $urandom_range(0, 4) - 2;
                7:       v = $urandom_range(0, 1) ? FULL_SCALE : 0;
                8:       v = (w > b) ? $urandom_range(b, w) : $urandom_range(0, FULL_SCALE);
                default: v = $urandom_range(0, FULL_SCALE);
            endcase
            if (v < 0)
                v = 0;
            if (v > FULL_SCALE)
                v = FULL_SCALE;
            f[ch] = v[lsc_pkg::SAMPLE_W-1:0];
        end
        return f;
    endfunction

    // Reset calibration: full dark, full white, held error, single-channel extremes
    task automatic test_reset_calibration();
        send_frame(flat_frame(0));
        send_frame(flat_frame(FULL_SCALE));
        send_frame({12'd0, {7{12'd4095}}});     // channel 7 first: only channel 7 dark
        send_frame({{7{12'd4095}}, 12'd0});     // only channel 0 dark
        send_frame(flat_frame(FULL_SCALE));
        send_frame(flat_frame(2048));
        send_frame({4{12'd0, 12'd4095}});
        send_frame({12'd17, 12'd3000, 12'd4094, 12'd1, 12'd2730, 12'd1365, 12'd1000, 12'd2});
    endtask

    // Thresholds at 2300 and 1300 for black 300, white 3300
    task automatic test_hysteresis();
        load_calibration(flat_frame(3300), flat_frame(300));
        send_frame(flat_frame(2300));
        send_frame(flat_frame(1800));
        send_frame(flat_frame(1300));
        send_frame(flat_frame(1800));
        send_frame(flat_frame(2299));
        send_frame(flat_frame(1301));
        send_frame({12'd3300, 12'd3299, 12'd2300, 12'd2299,
                    12'd1301, 12'd1300, 12'd301, 12'd300});
        send_frame({12'd4095, 12'd0, 12'd4095, 12'd0, 12'd1800, 12'd1800, 12'd2301, 12'd1299});
    endtask

    // White at zero under black at full scale, and white equal to black: bits hold
    task automatic test_invalid_calibration();
        load_calibration({flat_frame(2000)} & {{4{12'hFFF}}, 48'd0},
                         {flat_frame(2000)} | {48'd0, {4{12'hFFF}}});
        send_frame(flat_frame(0));
        send_frame(flat_frame(FULL_SCALE));
        send_frame(flat_frame(2000));
        send_frame({12'd2001, 12'd1999, 12'd4095, 12'd0, 12'd4095, 12'd1, 12'd4094, 12'd0});
    endtask

    task automatic test_random_frames(input t_cal_style style, input int send_pct,
                                      input int recv_pct);
        t_frame white, black;
        rand_calibration(style, white, black);
        load_calibration(white, black);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
            // occasional all-white frame gives zero strength when every channel has white above black
            if ($urandom_range(0, 19) == 0)
                send_frame(flat_frame(FULL_SCALE));
            else
                send_frame(rand_frame());
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 30;
        test_reset_calibration();
        test_hysteresis();
        test_invalid_calibration();

        test_random_frames(CAL_FULL, 0, 0);
        test_random_frames(CAL_SPREAD, 30, 30);
        test_random_frames(CAL_NARROW, 20, 50);
        test_random_frames(CAL_MIXED, 50, 20);
        test_random_frames(CAL_SPREAD, 10, 10);
        test_random_frames(CAL_MIXED, 0, 60);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
